/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the shared-buffer queue unit.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/mqsb_pkg.sv */
// Types, constants and helpers of the shared-buffer queue unit.
// Used by every module in rtl/core except mqsb_ram; depends on nothing.
package mqsb_pkg;

	localparam int ENTRIES = 64;
	localparam int QUEUES  = 4;
	localparam int DATA_W  = 32;
	localparam int QID_W   = 2;
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int PTR_W   = ADDR_W + 1;
	localparam int QIDX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [QIDX_W-1:0] qidx_t;

	// A pointer equal to ENTRIES marks the end of a chain
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(ENTRIES);

	typedef enum logic {
		ACT_ENQUEUE = 1'b0,
		ACT_DEQUEUE = 1'b1
	} act_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_FIN  = 1'b1
	} state_t;

	typedef struct packed {
		act_t               action;
		logic [QID_W-1:0]   queue_id;
		logic signed [DATA_W-1:0] data_in;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [DATA_W-1:0] data_out;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic finish;
	} ctrl_cmd_t;

	function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
		return p < NULL_PTR;
	endfunction

endpackage

/* rtl/core/multi_queue_shared_buffer_unit.sv */
// Top level of the shared-buffer queue unit: several FIFO queues in one store.
// Depends on mqsb_pkg, mqsb_ctrl, mqsb_dp, mqsb_ram and assert_macros.svh.
//
//   channel   ports                      handshake
//   -------   ------------------------   ------------------------------
//   command   start, busy, item          taken when start=1 and busy=0
//   result    done, result               one-cycle strobe, no backpressure
//
// Each word is taken in an accept cycle that reads the link and payload RAMs;
// the next cycle relinks through the single link RAM write port.
// The result strobes in the cycle after that, while the next word may be taken.
// Reset clears queue pointers and the free list at once; no clearing pass.
`include "assert_macros.svh"

module multi_queue_shared_buffer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mqsb_pkg::in_item_t  item,
	output logic                done,
	output mqsb_pkg::out_item_t result
);

	mqsb_pkg::ctrl_cmd_t cmd;

	mqsb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	mqsb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.done   (done),
		.result (result)
	);

	`ASSERT_NEXT(a_accept_then_busy, start && !busy, busy && !done)
	`ASSERT_NEXT(a_busy_then_done, busy, done && !busy)
	`ASSERT_IMPLIES(a_underflow_data, done && (result.status == mqsb_pkg::STATUS_UNDERFLOW), result.data_out == '1)
	`ASSERT_IMPLIES(a_overflow_data, done && (result.status == mqsb_pkg::STATUS_OVERFLOW), result.data_out == '0)

endmodule

/* rtl/core/mqsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module mqsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/mqsb_ctrl.sv */
// Controller of the shared-buffer queue unit: two-state sequencer.
// Depends on mqsb_pkg.
module mqsb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output mqsb_pkg::ctrl_cmd_t cmd
);

	mqsb_pkg::state_t state_q;
	mqsb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqsb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mqsb_pkg::ST_IDLE: begin
				if (start) begin
					state_d = mqsb_pkg::ST_FIN;
				end
			end
			mqsb_pkg::ST_FIN: begin
				state_d = mqsb_pkg::ST_IDLE;
			end
			default: begin
				state_d = mqsb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		cmd.accept = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			mqsb_pkg::ST_IDLE: begin
				cmd.accept = start;
			end
			mqsb_pkg::ST_FIN: begin
				busy       = 1'b1;
				cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/mqsb_dp.sv */
// Datapath of the shared-buffer queue unit: queue pointers, free list,
// link and payload RAMs, result register. Depends on mqsb_pkg and mqsb_ram.
module mqsb_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mqsb_pkg::ctrl_cmd_t  cmd,
	input  mqsb_pkg::in_item_t   item,
	output logic                 done,
	output mqsb_pkg::out_item_t  result
);

	mqsb_pkg::ptr_t head_q [mqsb_pkg::QUEUES];
	mqsb_pkg::ptr_t tail_q [mqsb_pkg::QUEUES];
	mqsb_pkg::ptr_t free_head_q;
	// Entries at or above this mark have never been allocated; their link is index+1
	mqsb_pkg::ptr_t fresh_q;

	// Operation held between the accept and finish cycles
	mqsb_pkg::act_t      act_q;
	mqsb_pkg::qidx_t     qidx_q;
	logic                err_q;
	mqsb_pkg::addr_t     slot_q;
	logic                fresh_hit_q;

	logic                done_q;
	mqsb_pkg::out_item_t res_q;

	logic                qok;
	mqsb_pkg::qidx_t     qidx;
	mqsb_pkg::ptr_t      hd_sel;
	mqsb_pkg::ptr_t      tl_sel;
	logic                acc_enq;
	logic                acc_err;
	mqsb_pkg::addr_t     acc_slot;
	mqsb_pkg::ptr_t      link_next;

	logic                link_we;
	mqsb_pkg::addr_t     link_waddr;
	mqsb_pkg::ptr_t      link_wdata;
	mqsb_pkg::ptr_t      link_rdata;
	logic                pay_we;
	logic [mqsb_pkg::DATA_W-1:0] pay_rdata;

	always_comb begin
		qok     = int'(item.queue_id) < mqsb_pkg::QUEUES;
		qidx    = mqsb_pkg::qidx_t'(item.queue_id);
		hd_sel  = qok ? head_q[qidx] : mqsb_pkg::NULL_PTR;
		tl_sel  = qok ? tail_q[qidx] : mqsb_pkg::NULL_PTR;
		acc_enq = (item.action == mqsb_pkg::ACT_ENQUEUE);
		if (acc_enq) begin
			acc_err  = !qok || !mqsb_pkg::ptr_ok(free_head_q);
			acc_slot = free_head_q[mqsb_pkg::ADDR_W-1:0];
		end else begin
			acc_err  = !qok || !mqsb_pkg::ptr_ok(hd_sel);
			acc_slot = hd_sel[mqsb_pkg::ADDR_W-1:0];
		end
		link_next = fresh_hit_q ?
			(mqsb_pkg::ptr_t'(slot_q) + mqsb_pkg::ptr_t'(1)) : link_rdata;
	end

	// Link RAM write: finish-cycle relink of the slot, or accept-cycle tail link
	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = mqsb_pkg::NULL_PTR;
		if (cmd.finish && !err_q) begin
			link_we    = 1'b1;
			link_waddr = slot_q;
			link_wdata = (act_q == mqsb_pkg::ACT_ENQUEUE) ? mqsb_pkg::NULL_PTR : free_head_q;
		end else if (cmd.accept && acc_enq && !acc_err &&
				mqsb_pkg::ptr_ok(hd_sel) && mqsb_pkg::ptr_ok(tl_sel)) begin
			link_we    = 1'b1;
			link_waddr = tl_sel[mqsb_pkg::ADDR_W-1:0];
			link_wdata = free_head_q;
		end
		pay_we = cmd.accept && acc_enq && !acc_err;
	end

	mqsb_ram #(
		.WIDTH(mqsb_pkg::PTR_W),
		.DEPTH(mqsb_pkg::ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (acc_slot),
		.rdata (link_rdata)
	);

	mqsb_ram #(
		.WIDTH(mqsb_pkg::DATA_W),
		.DEPTH(mqsb_pkg::ENTRIES)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (acc_slot),
		.wdata (item.data_in),
		.raddr (acc_slot),
		.rdata (pay_rdata)
	);

	// Capture the operation at accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q       <= item.action;
			qidx_q      <= qidx;
			err_q       <= acc_err;
			slot_q      <= acc_slot;
			fresh_hit_q <= mqsb_pkg::ptr_t'(acc_slot) >= fresh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
				head_q[i] <= mqsb_pkg::NULL_PTR;
				tail_q[i] <= mqsb_pkg::NULL_PTR;
			end
			free_head_q <= '0;
			fresh_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish && !err_q) begin
				if (act_q == mqsb_pkg::ACT_ENQUEUE) begin
					free_head_q <= link_next;
					if (!mqsb_pkg::ptr_ok(head_q[qidx_q])) begin
						head_q[qidx_q] <= mqsb_pkg::ptr_t'(slot_q);
					end
					tail_q[qidx_q] <= mqsb_pkg::ptr_t'(slot_q);
					if (mqsb_pkg::ptr_t'(slot_q) == fresh_q) begin
						fresh_q <= fresh_q + mqsb_pkg::ptr_t'(1);
					end
				end else begin
					head_q[qidx_q] <= link_next;
					free_head_q    <= mqsb_pkg::ptr_t'(slot_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (act_q == mqsb_pkg::ACT_ENQUEUE) begin
				res_q.status   <= err_q ? mqsb_pkg::STATUS_OVERFLOW : mqsb_pkg::STATUS_OK;
				res_q.data_out <= '0;
			end else if (err_q) begin
				res_q.status   <= mqsb_pkg::STATUS_UNDERFLOW;
				res_q.data_out <= '1;
			end else begin
				res_q.status   <= mqsb_pkg::STATUS_OK;
				res_q.data_out <= pay_rdata;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
